@@ design/bsft_pkg.sv @@
// Shared constants, register codes and divider interface types for the frequency table.
package bsft_pkg;

  // Table geometry.
  localparam int TABLE_SLOTS = 16;
  localparam int BIN_LIMIT   = 16;

  // Field widths.
  localparam int READ_W    = 12;
  localparam int BINCNT_W  = 5;
  localparam int FREQ_W    = 8;
  localparam int BIN_W     = $clog2(BIN_LIMIT + 1);
  localparam int SLOT_W    = $clog2(TABLE_SLOTS);
  localparam int FILL_W    = $clog2(TABLE_SLOTS + 1);
  localparam int MAP_IDX_W = $clog2(BIN_LIMIT);
  localparam int DIV_CNT_W = $clog2(READ_W);

  // Configuration port.
  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  localparam logic [1:0] REG_MIN_READING = 2'd0;
  localparam logic [1:0] REG_MAX_READING = 2'd1;
  localparam logic [1:0] REG_BIN_COUNT   = 2'd2;

  localparam logic [READ_W-1:0]   MIN_RESET    = READ_W'(0);
  localparam logic [READ_W-1:0]   MAX_RESET    = READ_W'(800);
  localparam logic [BINCNT_W-1:0] BINCNT_RESET = BINCNT_W'(8);

  localparam logic [FREQ_W-1:0] FREQ_MAX = '1;

  // Request to the shared divider.
  typedef struct packed {
    logic              start;
    logic [READ_W-1:0] dividend;
    logic [READ_W-1:0] divisor;
  } div_req_t;

  // Response from the shared divider; quotient and remainder hold until the next start.
  typedef struct packed {
    logic              done;
    logic [READ_W-1:0] quotient;
    logic [READ_W-1:0] remainder;
  } div_rsp_t;

endpackage

@@ design/bsft_div.sv @@
// Restoring divider that retires one quotient bit per cycle.
module bsft_div (
  input  logic               clk,
  input  logic               rst_n,
  input  bsft_pkg::div_req_t req,
  output bsft_pkg::div_rsp_t rsp
);

  logic                           busy_r;
  logic                           done_r;
  logic [bsft_pkg::DIV_CNT_W-1:0] cnt_r;
  logic [bsft_pkg::READ_W-1:0]    rem_r;
  logic [bsft_pkg::READ_W-1:0]    quo_r;
  logic [bsft_pkg::READ_W-1:0]    div_r;
  logic [bsft_pkg::READ_W:0]      shifted;
  logic [bsft_pkg::READ_W:0]      trial;

  // One trial subtraction of the divisor from the partial remainder.
  always_comb begin
    shifted = {rem_r, quo_r[bsft_pkg::READ_W-1]};
    trial   = shifted - {1'b0, div_r};
  end

  // Control: start loads the operands, the count runs down to the last bit.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start && !busy_r) begin
        busy_r <= 1'b1;
        cnt_r  <= bsft_pkg::DIV_CNT_W'(bsft_pkg::READ_W - 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath: the dividend shifts out of the quotient register as quotient bits shift in.
  always_ff @(posedge clk) begin
    if (req.start && !busy_r) begin
      rem_r <= '0;
      quo_r <= req.dividend;
      div_r <= req.divisor;
    end else if (busy_r) begin
      if (!trial[bsft_pkg::READ_W]) begin
        rem_r <= trial[bsft_pkg::READ_W-1:0];
        quo_r <= {quo_r[bsft_pkg::READ_W-2:0], 1'b1};
      end else begin
        rem_r <= shifted[bsft_pkg::READ_W-1:0];
        quo_r <= {quo_r[bsft_pkg::READ_W-2:0], 1'b0};
      end
    end
  end

  assign rsp.done      = done_r;
  assign rsp.quotient  = quo_r;
  assign rsp.remainder = rem_r;

endmodule

@@ design/binned_sample_frequency_table_top.sv @@
// Top level of the binned sample frequency table: configuration, sequencer and table storage.
// A sample result takes two divider passes (step, then bin), the update state and the output
// state; a zero bin count skips both passes and a zero step skips the second. A reorder runs
// the insertion sort over the filled slots, rewrites the map and then registers a zero result.
// The next transaction is accepted the cycle after the result registers.
// Synchronous active-low reset empties the table and restores the register defaults.
module binned_sample_frequency_table_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_kind,
  input  logic [bsft_pkg::READ_W-1:0]   in_reading,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [bsft_pkg::BIN_W-1:0]    out_bin_number,
  output logic [bsft_pkg::FREQ_W-1:0]   out_bin_frequency,
  output logic                          out_new_entry,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bsft_pkg::ADDR_W-1:0]   paddr,
  input  logic [bsft_pkg::DATA_W-1:0]   pwdata,
  output logic [bsft_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV_STEP,
    S_DIV_BIN,
    S_UPDATE,
    S_SORT_LOAD,
    S_SORT_SHIFT,
    S_MAP,
    S_OUT
  } state_t;

  // Configuration registers.
  logic [bsft_pkg::READ_W-1:0]   min_r;
  logic [bsft_pkg::READ_W-1:0]   max_r;
  logic [bsft_pkg::BINCNT_W-1:0] bincnt_r;
  logic                          cfg_we;
  logic [1:0]                    reg_idx;

  // Sequencer state.
  state_t                        state_r, state_nxt;
  logic [bsft_pkg::READ_W-1:0]   reading_r, reading_nxt;
  logic                          step_neg_r, step_neg_nxt;
  logic [bsft_pkg::BIN_W-1:0]    bin_r, bin_nxt;
  logic [bsft_pkg::FREQ_W-1:0]   freq_r, freq_nxt;
  logic                          fresh_r, fresh_nxt;
  logic [bsft_pkg::FILL_W-1:0]   filled_r, filled_nxt;
  logic [bsft_pkg::FILL_W-1:0]   i_r, i_nxt;
  logic [bsft_pkg::FILL_W-1:0]   j_r, j_nxt;
  logic [bsft_pkg::BIN_W-1:0]    key_bin_r, key_bin_nxt;
  logic [bsft_pkg::FREQ_W-1:0]   key_cnt_r, key_cnt_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic [bsft_pkg::BIN_W-1:0]    out_bin_r, out_bin_nxt;
  logic [bsft_pkg::FREQ_W-1:0]   out_freq_r, out_freq_nxt;
  logic                          out_new_r, out_new_nxt;

  // Table storage and its single read and write ports.
  logic [bsft_pkg::BIN_W-1:0]    slot_bin_r [bsft_pkg::TABLE_SLOTS];
  logic [bsft_pkg::FREQ_W-1:0]   slot_cnt_r [bsft_pkg::TABLE_SLOTS];
  logic [bsft_pkg::FILL_W-1:0]   map_r      [bsft_pkg::BIN_LIMIT];
  logic [bsft_pkg::SLOT_W-1:0]   rd_addr;
  logic [bsft_pkg::BIN_W-1:0]    rd_bin;
  logic [bsft_pkg::FREQ_W-1:0]   rd_cnt;
  logic                          tbl_we;
  logic [bsft_pkg::SLOT_W-1:0]   tbl_addr;
  logic [bsft_pkg::BIN_W-1:0]    tbl_bin;
  logic [bsft_pkg::FREQ_W-1:0]   tbl_cnt;
  logic                          map_we;
  logic [bsft_pkg::MAP_IDX_W-1:0] map_addr;
  logic [bsft_pkg::FILL_W-1:0]   map_val;

  // Arithmetic helpers.
  logic [bsft_pkg::READ_W:0]     span, span_inv, diff, diff_inv;
  logic                          span_neg, diff_neg;
  logic [bsft_pkg::READ_W-1:0]   span_mag, diff_mag;
  logic [bsft_pkg::BIN_W-1:0]    bin_m1, rd_bin_m1;
  logic [bsft_pkg::MAP_IDX_W-1:0] bin_idx;
  logic [bsft_pkg::FILL_W-1:0]   map_slot;
  logic [bsft_pkg::FILL_W-1:0]   j_m1;
  logic [bsft_pkg::READ_W:0]     q_ceil;
  bsft_pkg::div_req_t            div_req;
  bsft_pkg::div_rsp_t            div_rsp;

  bsft_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // Configuration port: writes complete in the access phase, reads return the register.
  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r    <= bsft_pkg::MIN_RESET;
      max_r    <= bsft_pkg::MAX_RESET;
      bincnt_r <= bsft_pkg::BINCNT_RESET;
    end else if (cfg_we) begin
      unique case (reg_idx)
        bsft_pkg::REG_MIN_READING: min_r    <= pwdata[bsft_pkg::READ_W-1:0];
        bsft_pkg::REG_MAX_READING: max_r    <= pwdata[bsft_pkg::READ_W-1:0];
        bsft_pkg::REG_BIN_COUNT:   bincnt_r <= pwdata[bsft_pkg::BINCNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      bsft_pkg::REG_MIN_READING: prdata = bsft_pkg::DATA_W'(min_r);
      bsft_pkg::REG_MAX_READING: prdata = bsft_pkg::DATA_W'(max_r);
      bsft_pkg::REG_BIN_COUNT:   prdata = bsft_pkg::DATA_W'(bincnt_r);
      default:                   prdata = '0;
    endcase
  end

  // Signed span and offset, split into sign and magnitude for the unsigned divider.
  always_comb begin
    span     = {1'b0, max_r} - {1'b0, min_r};
    span_inv = ~span + 1'b1;
    span_neg = span[bsft_pkg::READ_W];
    span_mag = span_neg ? span_inv[bsft_pkg::READ_W-1:0] : span[bsft_pkg::READ_W-1:0];
    diff     = {1'b0, reading_r} - {1'b0, min_r};
    diff_inv = ~diff + 1'b1;
    diff_neg = diff[bsft_pkg::READ_W];
    diff_mag = diff_neg ? diff_inv[bsft_pkg::READ_W-1:0] : diff[bsft_pkg::READ_W-1:0];
    q_ceil   = {1'b0, div_rsp.quotient} + {{bsft_pkg::READ_W{1'b0}}, (div_rsp.remainder != '0)};
  end

  // Table read port and map lookup.
  always_comb begin
    bin_m1   = bin_r - 1'b1;
    bin_idx  = bin_m1[bsft_pkg::MAP_IDX_W-1:0];
    map_slot = map_r[bin_idx];
    j_m1     = j_r - 1'b1;
    case (state_r)
      S_SORT_SHIFT:       rd_addr = j_m1[bsft_pkg::SLOT_W-1:0];
      S_SORT_LOAD, S_MAP: rd_addr = i_r[bsft_pkg::SLOT_W-1:0];
      default:            rd_addr = map_slot[bsft_pkg::SLOT_W-1:0];
    endcase
    rd_bin    = slot_bin_r[rd_addr];
    rd_cnt    = slot_cnt_r[rd_addr];
    rd_bin_m1 = rd_bin - 1'b1;
  end

  // Sequencer next-state logic.
  always_comb begin
    state_nxt     = state_r;
    reading_nxt   = reading_r;
    step_neg_nxt  = step_neg_r;
    bin_nxt       = bin_r;
    freq_nxt      = freq_r;
    fresh_nxt     = fresh_r;
    filled_nxt    = filled_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    key_bin_nxt   = key_bin_r;
    key_cnt_nxt   = key_cnt_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_bin_nxt   = out_bin_r;
    out_freq_nxt  = out_freq_r;
    out_new_nxt   = out_new_r;
    div_req.start    = 1'b0;
    div_req.dividend = span_mag;
    div_req.divisor  = bsft_pkg::READ_W'(bincnt_r);
    tbl_we   = 1'b0;
    tbl_addr = rd_addr;
    tbl_bin  = rd_bin;
    tbl_cnt  = rd_cnt;
    map_we   = 1'b0;
    map_addr = bin_idx;
    map_val  = filled_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          reading_nxt = in_reading;
          if (in_kind) begin
            i_nxt     = bsft_pkg::FILL_W'(1);
            state_nxt = S_SORT_LOAD;
          end else if (bincnt_r == '0) begin
            bin_nxt   = bsft_pkg::BIN_W'(bsft_pkg::BIN_LIMIT);
            state_nxt = S_UPDATE;
          end else begin
            div_req.start = 1'b1;
            state_nxt     = S_DIV_STEP;
          end
        end
      end

      // Step is known: a zero step sends the sample to the top bin.
      S_DIV_STEP: begin
        if (div_rsp.done) begin
          if (div_rsp.quotient == '0) begin
            bin_nxt   = bsft_pkg::BIN_W'(bsft_pkg::BIN_LIMIT);
            state_nxt = S_UPDATE;
          end else begin
            step_neg_nxt     = span_neg;
            div_req.start    = 1'b1;
            div_req.dividend = diff_mag;
            div_req.divisor  = div_rsp.quotient;
            state_nxt        = S_DIV_BIN;
          end
        end
      end

      // Ceiling of offset over step, clamped to the bin range.
      S_DIV_BIN: begin
        if (div_rsp.done) begin
          if (diff_mag == '0 || diff_neg != step_neg_r) begin
            bin_nxt = bsft_pkg::BIN_W'(1);
          end else if (q_ceil > (bsft_pkg::READ_W + 1)'(bsft_pkg::BIN_LIMIT)) begin
            bin_nxt = bsft_pkg::BIN_W'(bsft_pkg::BIN_LIMIT);
          end else begin
            bin_nxt = q_ceil[bsft_pkg::BIN_W-1:0];
          end
          state_nxt = S_UPDATE;
        end
      end

      // Count the sample in its slot, or open a new slot if there is room; a full table reports zero.
      S_UPDATE: begin
        if (map_slot < filled_r) begin
          tbl_we    = 1'b1;
          tbl_cnt   = (rd_cnt == bsft_pkg::FREQ_MAX) ? rd_cnt : rd_cnt + 1'b1;
          freq_nxt  = tbl_cnt;
          fresh_nxt = 1'b0;
        end else if (filled_r < bsft_pkg::FILL_W'(bsft_pkg::TABLE_SLOTS)) begin
          tbl_we     = 1'b1;
          tbl_addr   = filled_r[bsft_pkg::SLOT_W-1:0];
          tbl_bin    = bin_r;
          tbl_cnt    = bsft_pkg::FREQ_W'(1);
          map_we     = 1'b1;
          filled_nxt = filled_r + 1'b1;
          freq_nxt   = bsft_pkg::FREQ_W'(1);
          fresh_nxt  = 1'b1;
        end else begin
          freq_nxt  = '0;
          fresh_nxt = 1'b0;
        end
        state_nxt = S_OUT;
      end

      // Insertion sort: pick up the next key, or move on to the map rewrite.
      S_SORT_LOAD: begin
        if (i_r >= filled_r) begin
          i_nxt     = '0;
          state_nxt = S_MAP;
        end else begin
          key_bin_nxt = rd_bin;
          key_cnt_nxt = rd_cnt;
          j_nxt       = i_r;
          state_nxt   = S_SORT_SHIFT;
        end
      end

      // Shift larger counts up by one slot until the key's place is found.
      S_SORT_SHIFT: begin
        tbl_we   = 1'b1;
        tbl_addr = j_r[bsft_pkg::SLOT_W-1:0];
        if (j_r != '0 && rd_cnt > key_cnt_r) begin
          j_nxt = j_m1;
        end else begin
          tbl_bin   = key_bin_r;
          tbl_cnt   = key_cnt_r;
          i_nxt     = i_r + 1'b1;
          state_nxt = S_SORT_LOAD;
        end
      end

      // Point each bin's map entry at its slot after the sort.
      S_MAP: begin
        if (i_r >= filled_r) begin
          bin_nxt   = '0;
          freq_nxt  = '0;
          fresh_nxt = 1'b0;
          state_nxt = S_OUT;
        end else begin
          if (rd_bin != '0 && rd_bin <= bsft_pkg::BIN_W'(bsft_pkg::BIN_LIMIT)) begin
            map_we   = 1'b1;
            map_addr = rd_bin_m1[bsft_pkg::MAP_IDX_W-1:0];
            map_val  = i_r;
          end
          i_nxt = i_r + 1'b1;
        end
      end

      // Hand the result to the output register once it is free.
      S_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_bin_nxt   = bin_r;
          out_freq_nxt  = freq_r;
          out_new_nxt   = fresh_r;
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      filled_r    <= '0;
      out_valid_r <= 1'b0;
      out_bin_r   <= '0;
      out_freq_r  <= '0;
      out_new_r   <= 1'b0;
      i_r         <= '0;
      j_r         <= '0;
    end else begin
      state_r     <= state_nxt;
      filled_r    <= filled_nxt;
      out_valid_r <= out_valid_nxt;
      out_bin_r   <= out_bin_nxt;
      out_freq_r  <= out_freq_nxt;
      out_new_r   <= out_new_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    reading_r  <= reading_nxt;
    step_neg_r <= step_neg_nxt;
    bin_r      <= bin_nxt;
    freq_r     <= freq_nxt;
    fresh_r    <= fresh_nxt;
    key_bin_r  <= key_bin_nxt;
    key_cnt_r  <= key_cnt_nxt;
  end

  // Slot storage: at most one write per cycle.
  always_ff @(posedge clk) begin
    if (tbl_we) begin
      slot_bin_r[tbl_addr] <= tbl_bin;
      slot_cnt_r[tbl_addr] <= tbl_cnt;
    end
  end

  // Bin-to-slot map: every entry starts empty.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < bsft_pkg::BIN_LIMIT; k++) begin
        map_r[k] <= bsft_pkg::FILL_W'(bsft_pkg::TABLE_SLOTS);
      end
    end else if (map_we) begin
      map_r[map_addr] <= map_val;
    end
  end

  assign in_stall          = (state_r != S_IDLE);
  assign out_valid         = out_valid_r;
  assign out_bin_number    = out_bin_r;
  assign out_bin_frequency = out_freq_r;
  assign out_new_entry     = out_new_r;

endmodule

@@ design/bsft_checker.sv @@
// Port-level checks on the frequency table top level, attached by bind.
module bsft_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [bsft_pkg::BIN_W-1:0]    out_bin_number,
  input logic [bsft_pkg::FREQ_W-1:0]   out_bin_frequency,
  input logic                          out_new_entry
);

  // A stalled result holds its payload.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_bin_number) &&
      $stable(out_bin_frequency) && $stable(out_new_entry)))
    else $error("stalled result changed");

  // The block takes one transaction at a time, so it stalls right after an acceptance.
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input not stalled after acceptance");

  // A freshly opened slot always reports a count of one for a real bin.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_new_entry) |-> (out_bin_frequency == 1 && out_bin_number != 0))
    else $error("new entry with wrong count or bin");

  // Bins never exceed the bin limit.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_bin_number <= bsft_pkg::BIN_W'(bsft_pkg::BIN_LIMIT)))
    else $error("bin number out of range");

  // A reorder result carries nothing but zeros.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_bin_number == 0) |-> (out_bin_frequency == 0 && !out_new_entry))
    else $error("reorder result not zero");

endmodule

bind binned_sample_frequency_table_top bsft_checker u_bsft_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_stall          (in_stall),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_bin_number    (out_bin_number),
  .out_bin_frequency (out_bin_frequency),
  .out_new_entry     (out_new_entry)
);

@@ test/testbench.sv @@
// Self-checking testbench for the binned sample frequency table top level.
`timescale 1ns / 100ps

module testbench;

  localparam logic KIND_SAMPLE  = 1'b0;
  localparam logic KIND_REORDER = 1'b1;
  // The quiet limit leaves ample margin over the longest reorder of a full table.
  localparam int QUIET_LIMIT   = 5000;
  localparam int SETTLE_CYCLES = 40;

  typedef struct packed {
    logic                        kind;
    logic [bsft_pkg::READ_W-1:0] reading;
  } sample_item_t;

  typedef struct packed {
    logic [bsft_pkg::BIN_W-1:0]  bin_no;
    logic [bsft_pkg::FREQ_W-1:0] count;
    logic                        fresh;
  } tally_t;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic                          in_kind = 1'b0;
  logic [bsft_pkg::READ_W-1:0]   in_reading = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic [bsft_pkg::BIN_W-1:0]    out_bin_number;
  logic [bsft_pkg::FREQ_W-1:0]   out_bin_frequency;
  logic                          out_new_entry;
  logic                          psel = 1'b0;
  logic                          penable = 1'b0;
  logic                          pwrite = 1'b0;
  logic [bsft_pkg::ADDR_W-1:0]   paddr = '0;
  logic [bsft_pkg::DATA_W-1:0]   pwdata = '0;
  logic [bsft_pkg::DATA_W-1:0]   prdata;
  logic                          pready;

  sample_item_t pending_items[$];
  tally_t       expected_tallies[$];
  int           failures = 0;
  int           send_idle_pct = 35;
  int           recv_idle_pct = 55;
  int           quiet_cycles = 0;

  // Predictor copy of the registers and the frequency table.
  logic [bsft_pkg::READ_W-1:0]   span_min = bsft_pkg::MIN_RESET;
  logic [bsft_pkg::READ_W-1:0]   span_max = bsft_pkg::MAX_RESET;
  logic [bsft_pkg::BINCNT_W-1:0] span_bins = bsft_pkg::BINCNT_RESET;
  logic [bsft_pkg::BIN_W-1:0]    tally_bin[bsft_pkg::TABLE_SLOTS];
  logic [bsft_pkg::FREQ_W-1:0]   tally_count[bsft_pkg::TABLE_SLOTS];
  int                            bin_slot[bsft_pkg::BIN_LIMIT] =
                                   '{default: bsft_pkg::TABLE_SLOTS};
  int                            slots_used = 0;

  always #5 clk = ~clk;

  binned_sample_frequency_table_top DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_kind           (in_kind),
    .in_reading        (in_reading),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_bin_number    (out_bin_number),
    .out_bin_frequency (out_bin_frequency),
    .out_new_entry     (out_new_entry),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  // Bin of a reading: exact signed ceiling of the offset over the step, clamped.
  function automatic int bin_of_reading(input int reading);
    int span;
    int step;
    int diff;
    int q;
    int r;
    span = int'(span_max) - int'(span_min);
    if (span_bins == 0) return bsft_pkg::BIN_LIMIT;
    step = span / int'(span_bins);
    if (step == 0) return bsft_pkg::BIN_LIMIT;
    diff = reading - int'(span_min);
    q = diff / step;
    r = diff % step;
    if (r != 0 && ((diff > 0) == (step > 0))) q = q + 1;
    if (q < 1) return 1;
    if (q > bsft_pkg::BIN_LIMIT) return bsft_pkg::BIN_LIMIT;
    return q;
  endfunction

  // Stable insertion sort of the filled slots by count, then the map is rebuilt.
  function automatic void sort_by_count();
    int                          j;
    logic [bsft_pkg::BIN_W-1:0]  kb;
    logic [bsft_pkg::FREQ_W-1:0] kc;
    for (int i = 1; i < slots_used; i++) begin
      kb = tally_bin[i];
      kc = tally_count[i];
      j = i;
      while (j > 0 && tally_count[j-1] > kc) begin
        tally_bin[j] = tally_bin[j-1];
        tally_count[j] = tally_count[j-1];
        j--;
      end
      tally_bin[j] = kb;
      tally_count[j] = kc;
    end
    for (int i = 0; i < slots_used; i++) begin
      if (tally_bin[i] >= 1 && tally_bin[i] <= bsft_pkg::BIN_LIMIT) begin
        bin_slot[tally_bin[i] - 1] = i;
      end
    end
  endfunction

  // Works out the result of one accepted transaction and updates the table copy.
  function automatic tally_t predict_tally(input sample_item_t item);
    tally_t res;
    int     b;
    int     s;
    res = '0;
    if (item.kind == KIND_REORDER) begin
      sort_by_count();
      return res;
    end
    b = bin_of_reading(int'(item.reading));
    s = bin_slot[b - 1];
    res.bin_no = bsft_pkg::BIN_W'(b);
    if (s < slots_used && s < bsft_pkg::TABLE_SLOTS) begin
      if (tally_count[s] != bsft_pkg::FREQ_MAX) tally_count[s] = tally_count[s] + 1'b1;
      res.count = tally_count[s];
    end else if (slots_used < bsft_pkg::TABLE_SLOTS) begin
      tally_bin[slots_used] = bsft_pkg::BIN_W'(b);
      tally_count[slots_used] = 1;
      bin_slot[b - 1] = slots_used;
      slots_used++;
      res.count = 1;
      res.fresh = 1'b1;
    end
    return res;
  endfunction

  // Input driver: predicts each accepted transaction and presents the next pending one.
  always @(posedge clk) begin : driver
    sample_item_t next_item;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_tallies.push_back(predict_tally('{kind: in_kind, reading: in_reading}));
      end
      if (!in_valid || !in_stall) begin
        if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_item = pending_items.pop_front();
          in_valid <= 1'b1;
          in_kind <= next_item.kind;
          in_reading <= next_item.reading;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compares each accepted result with the oldest expectation.
  always @(posedge clk) begin : monitor
    tally_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_tallies.size() == 0) begin
          $error("result with no transaction outstanding: bin_number %0d", out_bin_number);
          failures++;
        end else begin
          want = expected_tallies.pop_front();
          if (out_bin_number !== want.bin_no) begin
            $error("bin_number: expected %0d, got %0d", want.bin_no, out_bin_number);
            failures++;
          end
          if (out_bin_frequency !== want.count) begin
            $error("bin_frequency: expected %0d, got %0d", want.count, out_bin_frequency);
            failures++;
          end
          if (out_new_entry !== want.fresh) begin
            $error("new_entry: expected %0d, got %0d", want.fresh, out_new_entry);
            failures++;
          end
        end
      end
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Watchdog on cycles in which neither channel moves a transaction.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic add_item(input logic kind, input int reading);
    pending_items.push_back('{kind: kind, reading: bsft_pkg::READ_W'(reading)});
  endtask

  // Waits until every transaction has been accepted and answered, then lets the block settle.
  task automatic wait_idle();
    do @(negedge clk);
    while (pending_items.size() != 0 || in_valid || expected_tallies.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // One register write: setup cycle then access cycle.
  task automatic write_register(input logic [1:0] index, input int value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= bsft_pkg::ADDR_W'({index, 2'b00});
    pwdata <= bsft_pkg::DATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic configure(input int lo_reading, input int hi_reading, input int bins_wanted);
    wait_idle();
    write_register(bsft_pkg::REG_MIN_READING, lo_reading);
    write_register(bsft_pkg::REG_MAX_READING, hi_reading);
    write_register(bsft_pkg::REG_BIN_COUNT, bins_wanted);
    span_min = bsft_pkg::READ_W'(lo_reading);
    span_max = bsft_pkg::READ_W'(hi_reading);
    span_bins = bsft_pkg::BINCNT_W'(bins_wanted);
    @(negedge clk);
  endtask

  // Mostly samples aimed at bin edges and inside the span, some anywhere, a few reorders.
  task automatic queue_random(input int total);
    int pick;
    int step;
    int value;
    int lo;
    int hi;
    for (int n = 0; n < total; n++) begin
      pick = $urandom_range(99);
      lo = (span_min < span_max) ? int'(span_min) : int'(span_max);
      hi = (span_min < span_max) ? int'(span_max) : int'(span_min);
      if (pick < 10) begin
        add_item(KIND_REORDER, $urandom_range(4095));
      end else if (pick < 45) begin
        add_item(KIND_SAMPLE, $urandom_range(4095));
      end else if (pick < 80) begin
        step = (int'(span_max) - int'(span_min)) / int'(span_bins);
        value = int'(span_min) + int'($urandom_range(int'(span_bins) + 1)) * step;
        value = value + int'($urandom_range(2)) - 1;
        if (value < 0) value = 0;
        if (value > 4095) value = 4095;
        add_item(KIND_SAMPLE, value);
      end else begin
        add_item(KIND_SAMPLE, $urandom_range(hi, lo));
      end
    end
  endtask

  // Equal minimum and maximum with a bin count of 16.
  task automatic value_zero_step();
    int level;
    level = $urandom_range(4095);
    configure(level, level, 16);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset span of 0 to 800 in 8 bins: reorder of an empty table, edges and clamping.
    add_item(KIND_REORDER, 4095);
    add_item(KIND_SAMPLE, 0);
    add_item(KIND_SAMPLE, 1);
    add_item(KIND_SAMPLE, 100);
    add_item(KIND_SAMPLE, 101);
    add_item(KIND_SAMPLE, 800);
    add_item(KIND_SAMPLE, 801);
    add_item(KIND_SAMPLE, 4095);
    add_item(KIND_SAMPLE, 1700);
    add_item(KIND_SAMPLE, 101);
    add_item(KIND_REORDER, 0);
    add_item(KIND_SAMPLE, 800);
    add_item(KIND_SAMPLE, 2730);

    // Maximum below minimum gives a negative step.
    configure(4095, 0, 16);
    add_item(KIND_SAMPLE, 0);
    add_item(KIND_SAMPLE, 4095);
    add_item(KIND_SAMPLE, 2000);
    add_item(KIND_REORDER, 1365);

    // Zero step, both from an empty span and from a span smaller than the bin count.
    configure(2048, 2048, 1);
    add_item(KIND_SAMPLE, 2048);
    add_item(KIND_SAMPLE, 0);
    configure(10, 20, 16);
    add_item(KIND_SAMPLE, 15);
    add_item(KIND_REORDER, 7);

    // Sender idles less than the receiver.
    configure(0, 4095, 16);
    queue_random(85);
    configure($urandom_range(500), $urandom_range(4095, 2000), $urandom_range(16, 1));
    queue_random(85);

    // Receiver idles less than the sender.
    wait_idle();
    send_idle_pct = 55;
    recv_idle_pct = 35;
    configure(4095, 0, $urandom_range(16, 1));
    queue_random(85);
    configure($urandom_range(4095), $urandom_range(4095), $urandom_range(16, 1));
    queue_random(85);

    // No idling; the zero-step stretch drives the busiest bin into saturation.
    wait_idle();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    configure($urandom_range(4095), $urandom_range(4095), 1);
    queue_random(85);
    value_zero_step();
    queue_random(300);

    wait_idle();
    if (expected_tallies.size() != 0) begin
      $error("%0d expected results never arrived", expected_tallies.size());
      failures++;
    end
    if (failures == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
